[src/ipap_pkg.sv]
// Shared types and constants of the partial IPv4 address parser.
package ipap_pkg;

    localparam int unsigned CharWidth = 8;
    localparam int unsigned AddrWidth = 32;
    localparam int unsigned PortWidth = 16;

    localparam logic [AddrWidth-1:0] LocalAddressReset = 32'h7F00_0001;
    localparam logic [PortWidth-1:0] DefaultPortReset  = 16'd26000;

    localparam logic [CharWidth-1:0] CharNul   = 8'h00;
    localparam logic [CharWidth-1:0] CharDot   = 8'h2E;
    localparam logic [CharWidth-1:0] CharColon = 8'h3A;
    localparam logic [CharWidth-1:0] CharZero  = 8'h30;
    localparam logic [CharWidth-1:0] CharNine  = 8'h39;

    localparam logic [9:0] OctetMax    = 10'd255;
    localparam logic [1:0] MaxDigitRun = 2'd3;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_LOCAL_ADDRESS = 1'b0,
        CFG_DEFAULT_PORT  = 1'b1
    } t_cfg_index;

    typedef enum logic [2:0] {
        PH_START     = 3'd0,
        PH_OCTET     = 3'd1,
        PH_PORT      = 3'd2,
        PH_PORT_DONE = 3'd3,
        PH_ERROR     = 3'd4
    } t_phase;

    typedef struct packed {
        logic                 emit;
        logic                 status;
        logic [AddrWidth-1:0] address;
        logic [PortWidth-1:0] port;
    } t_result;

endpackage

[src/ipap_core.sv]
// Parse state registers and the per-character update logic.
module ipap_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_step,
    input  logic [ipap_pkg::CharWidth-1:0]   i_char,
    input  logic [ipap_pkg::AddrWidth-1:0]   i_local_address,
    input  logic [ipap_pkg::PortWidth-1:0]   i_default_port,
    output ipap_pkg::t_result                o_result
);
    import ipap_pkg::*;

    t_phase                r_phase,  n_phase;
    logic [9:0]            r_octet,  n_octet;
    logic [1:0]            r_run,    n_run;
    logic [AddrWidth-1:0]  r_bits,   n_bits;
    logic [AddrWidth-1:0]  r_mask,   n_mask;
    logic [PortWidth-1:0]  r_port,   n_port;

    logic                  is_digit;
    logic [3:0]            digit;
    logic                  octet_ok;
    logic [AddrWidth-1:0]  mask_c;
    logic [AddrWidth-1:0]  bits_c;
    t_phase                eff_phase;

    assign is_digit = (i_char >= CharZero) && (i_char <= CharNine);
    assign digit    = 4'(i_char - CharZero);
    assign octet_ok = (r_octet <= OctetMax);
    assign mask_c   = {r_mask[AddrWidth-9:0], 8'h00};
    assign bits_c   = {r_bits[AddrWidth-9:0], r_octet[7:0]};
    // A string that does not open with a dot behaves as if it did.
    assign eff_phase = (r_phase == PH_START) ? PH_OCTET : r_phase;

    always_comb begin
        n_phase  = r_phase;
        n_octet  = r_octet;
        n_run    = r_run;
        n_bits   = r_bits;
        n_mask   = r_mask;
        n_port   = r_port;
        o_result = '0;

        if (r_phase == PH_START && i_char == CharDot) begin
            n_phase = PH_OCTET;
        end else begin
            case (eff_phase)
                PH_OCTET: begin
                    n_phase = PH_OCTET;
                    if (is_digit) begin
                        if (r_run == MaxDigitRun) begin
                            n_phase = PH_ERROR;
                        end else begin
                            n_run   = r_run + 2'd1;
                            n_octet = r_octet * 10'd10 + {6'd0, digit};
                        end
                    end else if (i_char == CharDot || i_char == CharColon) begin
                        if (!octet_ok) begin
                            n_phase = PH_ERROR;
                        end else begin
                            n_mask  = mask_c;
                            n_bits  = bits_c;
                            n_octet = '0;
                            n_run   = '0;
                            if (i_char == CharColon) begin
                                n_phase = PH_PORT;
                            end
                        end
                    end else if (i_char == CharNul) begin
                        o_result.emit    = 1'b1;
                        o_result.status  = !octet_ok;
                        o_result.address = octet_ok ? ((i_local_address & mask_c) | bits_c) : '0;
                        o_result.port    = octet_ok ? i_default_port : '0;
                    end else begin
                        n_phase = PH_ERROR;
                    end
                end
                PH_PORT, PH_PORT_DONE: begin
                    if (i_char == CharNul) begin
                        o_result.emit    = 1'b1;
                        o_result.status  = 1'b0;
                        o_result.address = (i_local_address & r_mask) | r_bits;
                        o_result.port    = r_port;
                    end else if (r_phase == PH_PORT) begin
                        if (is_digit) begin
                            n_port = r_port * 16'd10 + {12'd0, digit};
                        end else begin
                            n_phase = PH_PORT_DONE;
                        end
                    end
                end
                default: begin
                    n_phase = PH_ERROR;
                    if (i_char == CharNul) begin
                        o_result.emit   = 1'b1;
                        o_result.status = 1'b1;
                    end
                end
            endcase
        end

        // Every result closes the string and starts the next one afresh.
        if (o_result.emit) begin
            n_phase = PH_START;
            n_octet = '0;
            n_run   = '0;
            n_bits  = '0;
            n_mask  = '1;
            n_port  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
            r_octet <= '0;
            r_run   <= '0;
            r_bits  <= '0;
            r_mask  <= '1;
            r_port  <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_octet <= n_octet;
            r_run   <= n_run;
            r_bits  <= n_bits;
            r_mask  <= n_mask;
            r_port  <= n_port;
        end
    end

endmodule

[src/ipap_out.sv]
// Result register that holds one finished beat until the receiver takes it.
module ipap_out (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_load,
    input  ipap_pkg::t_result                i_result,
    input  logic                             i_ready,
    output logic                             o_free,
    output logic                             o_valid,
    output logic                             o_status,
    output logic [ipap_pkg::AddrWidth-1:0]   o_address,
    output logic [ipap_pkg::PortWidth-1:0]   o_port
);
    import ipap_pkg::*;

    logic                 r_valid;
    logic                 r_status;
    logic [AddrWidth-1:0] r_address;
    logic [PortWidth-1:0] r_port;

    assign o_free    = !r_valid || i_ready;
    assign o_valid   = r_valid;
    assign o_status  = r_status;
    assign o_address = r_address;
    assign o_port    = r_port;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_status  <= i_result.status;
            r_address <= i_result.address;
            r_port    <= i_result.port;
        end
    end

endmodule

[src/partial_ipv4_address_parser.sv]
// Top level of the partial dotted-decimal IPv4 address parser.
//
// The slave stream carries the address text, one character per beat, ended by
// a zero byte. The block answers each zero byte with one master beat: tuser is
// the status (0 parsed, 1 malformed), tdata holds the address and the port.
// Characters other than the terminator produce no output beat.
//
// An accepted character lands in an input register; the parse logic then
// consumes it and, on a terminator, writes the result register, so a result
// passes the input register and the result register before it can be taken.
// One character is taken per cycle, sustained, unless a terminator waits on a
// full result register; the parse registers advance per consumed character.
//
// When the receiver stalls, a finished result waits in the result register
// while further characters keep flowing; only a second terminator blocks until
// the waiting result is taken, so the input register then holds it.
//
// Reset (synchronous, active low) clears the parse state and the valid flags
// and loads the register defaults: local address 127.0.0.1 and port 26000.
// The configuration port is to be written by the user only while the block is idle; the block does not enforce this.
module partial_ipv4_address_parser (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Slave stream, tdata: char_code [7:0].
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  logic [7:0]                       i_s_axis_tdata,
    // Master stream, tdata: address [31:0], port [47:32]; tuser: status [0].
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    output logic [47:0]                      o_m_axis_tdata,
    output logic [0:0]                       o_m_axis_tuser,
    // Configuration write port: index 0 local_address, index 1 default_port.
    input  logic                             i_cfg_we,
    input  logic [0:0]                       i_cfg_index,
    input  logic [31:0]                      i_cfg_wdata
);
    import ipap_pkg::*;

    logic                 r_in_valid;
    logic [CharWidth-1:0] r_in_char;
    logic [AddrWidth-1:0] r_local_address;
    logic [PortWidth-1:0] r_default_port;

    t_result              step_result;
    logic                 out_free;
    logic                 step_fire;
    logic                 in_fire;
    logic                 out_status;
    logic [AddrWidth-1:0] out_address;
    logic [PortWidth-1:0] out_port;

    // A held character is consumed unless it is a terminator whose result
    // has nowhere to go yet.
    assign step_fire       = r_in_valid && (r_in_char != CharNul || out_free);
    assign o_s_axis_tready = !r_in_valid || step_fire;
    assign in_fire         = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_fire) begin
            r_in_valid <= 1'b1;
        end else if (step_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_char <= i_s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_address <= LocalAddressReset;
            r_default_port  <= DefaultPortReset;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_LOCAL_ADDRESS: r_local_address <= i_cfg_wdata;
                CFG_DEFAULT_PORT:  r_default_port  <= i_cfg_wdata[PortWidth-1:0];
                default:           r_local_address <= r_local_address;
            endcase
        end
    end

    ipap_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (step_fire),
        .i_char          (r_in_char),
        .i_local_address (r_local_address),
        .i_default_port  (r_default_port),
        .o_result        (step_result)
    );

    ipap_out u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (step_fire && step_result.emit),
        .i_result  (step_result),
        .i_ready   (i_m_axis_tready),
        .o_free    (out_free),
        .o_valid   (o_m_axis_tvalid),
        .o_status  (out_status),
        .o_address (out_address),
        .o_port    (out_port)
    );

    assign o_m_axis_tdata = {out_port, out_address};
    assign o_m_axis_tuser = out_status;

    // A malformed result never carries an address or a port.
    a_error_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[0] |-> o_m_axis_tdata == '0)
        else $error("error result with nonzero payload");

    // A held character that cannot be consumed stays in the input register.
    a_in_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !step_fire |=> r_in_valid && $stable(r_in_char))
        else $error("input register lost a stalled character");

    // Only a terminator blocked by a full result register stalls the input.
    a_stall_cause : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> r_in_valid && r_in_char == CharNul && o_m_axis_tvalid)
        else $error("input stalled without a waiting result");

    // Only a consumed terminator produces a result.
    a_emit_term : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step_fire && step_result.emit |-> r_in_char == CharNul)
        else $error("result produced by a non-terminator");

endmodule
